FILE: rtl/m1m2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package m1m2_pkg;

   localparam int NUM_GROUPS   = 16;
   localparam int NUM_CHANNELS = 16;
   localparam int ENTRIES      = NUM_GROUPS * NUM_CHANNELS;
   localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // input message kinds
   localparam logic [2:0] KIND_NOTE_OFF   = 3'd0;
   localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
   localparam logic [2:0] KIND_POLY_PRESS = 3'd2;
   localparam logic [2:0] KIND_CTRL       = 3'd3;
   localparam logic [2:0] KIND_PROGRAM    = 3'd4;
   localparam logic [2:0] KIND_CHAN_PRESS = 3'd5;
   localparam logic [2:0] KIND_PITCH_BEND = 3'd6;
   localparam logic [2:0] KIND_UNUSED     = 3'd7;

   // extra result kinds
   localparam logic [3:0] OKIND_RPN  = 4'd7;
   localparam logic [3:0] OKIND_NRPN = 4'd8;

   // controller numbers
   localparam logic [6:0] CC_BANK_MSB   = 7'd0;
   localparam logic [6:0] CC_BANK_LSB   = 7'd32;
   localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
   localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
   localparam logic [6:0] CC_RPN_MSB    = 7'd101;
   localparam logic [6:0] CC_RPN_LSB    = 7'd100;
   localparam logic [6:0] CC_DATA_MSB   = 7'd6;
   localparam logic [6:0] CC_DATA_LSB   = 7'd38;
   localparam logic [6:0] CC_RESET_ALL  = 7'd121;
   localparam logic [6:0] NULL_NUMBER   = 7'h7F;

   typedef struct packed {
      logic [3:0] group;
      logic [2:0] kind;
      logic [3:0] chan;
      logic [6:0] data_one;
      logic [6:0] data_two;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_group;
      logic [3:0]  out_kind;
      logic [3:0]  out_chan;
      logic [6:0]  key;
      logic [6:0]  param_index;
      logic        has_bank;
      logic [6:0]  bank_high;
      logic [6:0]  bank_low;
      logic [31:0] wide_value;
   } rsp_type;

   // per group and channel state: bank select and parameter number
   typedef struct packed {
      logic       bank_hi_valid;
      logic       bank_lo_valid;
      logic [6:0] bank_hi;
      logic [6:0] bank_lo;
      logic       is_rpn;
      logic       num_msb_valid;
      logic       num_lsb_valid;
      logic       val_msb_valid;
      logic [6:0] num_msb;
      logic [6:0] num_lsb;
      logic [6:0] val_msb;
   } entry_type;

   // min-center-max upscaling
   function automatic logic [15:0] widen_7_16(input logic [6:0] v);
      logic [15:0] r;
      r = {v, 9'b0};
      if (v > 7'd64) begin
         r = r | {7'b0, v[5:0], 3'b0} | {13'b0, v[5:3]};
      end
      return r;
   endfunction

   function automatic logic [31:0] widen_7_32(input logic [6:0] v);
      logic [31:0] r;
      logic [24:0] rep;
      r   = {v, 25'b0};
      rep = {v[5:0], 19'b0};
      if (v > 7'd64) begin
         r = r | {7'b0, rep} | {13'b0, rep[24:6]} | {19'b0, rep[24:12]}
               | {25'b0, rep[24:18]} | {31'b0, rep[24]};
      end
      return r;
   endfunction

   function automatic logic [31:0] widen_14_32(input logic [13:0] v);
      logic [31:0] r;
      logic [17:0] rep;
      r   = {v, 18'b0};
      rep = {v[12:0], 5'b0};
      if (v > 14'd8192) begin
         r = r | {14'b0, rep} | {27'b0, rep[17:13]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/m1m2_channel_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface m1m2_req_if
   import m1m2_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [3:0] group;
   logic [2:0] kind;
   logic [3:0] chan;
   logic [6:0] data_one;
   logic [6:0] data_two;

   modport source (output valid, group, kind, chan, data_one, data_two, input ready);
   modport sink   (input valid, group, kind, chan, data_one, data_two, output ready);
endinterface

interface m1m2_rsp_if
   import m1m2_pkg::*;
();
   logic        valid;
   logic        ready;
   logic [3:0]  out_group;
   logic [3:0]  out_kind;
   logic [3:0]  out_chan;
   logic [6:0]  key;
   logic [6:0]  param_index;
   logic        has_bank;
   logic [6:0]  bank_high;
   logic [6:0]  bank_low;
   logic [31:0] wide_value;

   modport source (output valid, out_group, out_kind, out_chan, key, param_index,
                   has_bank, bank_high, bank_low, wide_value, input ready);
   modport sink   (input valid, out_group, out_kind, out_chan, key, param_index,
                   has_bank, bank_high, bank_low, wide_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/midi1_to_midi2_channel_voice_translator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake     payload
// req_port  in   valid/ready   group, kind, chan, data_one, data_two
// rsp_port  out  valid/ready   out_group .. wide_value, zero or one per item
//
// one item per cycle sustained while the result is not stalled; an accepted item passes
// through the input register (with state read), then the result register
// state is one read and one write of a 256-entry memory per item, with
// a write-to-read bypass for the next item; per-entry valid flops clear at reset
// a stalled result holds one item in the result register and one in the input stage

module midi1_to_midi2_channel_voice_translator
   import m1m2_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   m1m2_req_if.sink     req_port,
   m1m2_rsp_if.source   rsp_port
);

   entry_type              mem [ENTRIES];
   entry_type              rd_ff;
   logic [ENTRIES-1:0]     ent_valid_ff;
   logic [ENTRIES-1:0]     ent_valid_in;

   req_type                s1_req_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]       s1_idx_ff;
   logic                   s1_range_ff;

   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   acc, s1_go, s1_leave;
   logic                   in_range;
   logic [IDX_W-1:0]       rd_idx;
   logic                   wr_en;
   entry_type              cur, nxt;
   logic                   emit;
   req_type                q;

   assign acc      = req_port.valid && req_port.ready;
   assign s1_go    = !rsp_valid_ff || rsp_port.ready;
   assign s1_leave = s1_valid_ff && s1_go;
   assign req_port.ready = !s1_valid_ff || s1_go;

   assign in_range = (32'(req_port.group) < NUM_GROUPS) &&
                     (32'(req_port.chan) < NUM_CHANNELS);
   assign rd_idx   = in_range ?
                     IDX_W'(32'(req_port.group) * NUM_CHANNELS + 32'(req_port.chan)) :
                     '0;

   assign wr_en = s1_leave && s1_range_ff;

   // state memory with bypass of the write landing on the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_idx_ff] <= nxt;
      end
      if (acc) begin
         rd_ff <= (wr_en && s1_idx_ff == rd_idx) ? nxt : mem[rd_idx];
      end
   end

   always_comb begin
      ent_valid_in = ent_valid_ff;
      if (wr_en) begin
         ent_valid_in[s1_idx_ff] = 1'b1;
      end
   end

   assign s1_valid_in  = acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_go ? (s1_valid_ff && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_req_ff   <= '{group: req_port.group, kind: req_port.kind, chan: req_port.chan,
                          data_one: req_port.data_one, data_two: req_port.data_two};
         s1_idx_ff   <= rd_idx;
         s1_range_ff <= in_range;
      end
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   // translation and state update
   assign q   = s1_req_ff;
   assign cur = ent_valid_ff[s1_idx_ff] ? rd_ff : '0;

   always_comb begin
      nxt    = cur;
      emit   = 1'b1;
      rsp_in = '{out_group: q.group, out_kind: {1'b0, q.kind}, out_chan: q.chan,
                 key: 7'd0, param_index: 7'd0, has_bank: 1'b0, bank_high: 7'd0,
                 bank_low: 7'd0, wide_value: 32'd0};
      case (q.kind)
         KIND_NOTE_OFF, KIND_NOTE_ON: begin
            rsp_in.key        = q.data_one;
            rsp_in.wide_value = {16'b0, widen_7_16(q.data_two)};
         end
         KIND_POLY_PRESS: begin
            rsp_in.key        = q.data_one;
            rsp_in.wide_value = widen_7_32(q.data_two);
         end
         KIND_CTRL: begin
            rsp_in.key        = q.data_one;
            rsp_in.wide_value = widen_7_32(q.data_two);
            case (q.data_one)
               CC_BANK_MSB: begin
                  emit              = 1'b0;
                  nxt.bank_hi       = q.data_two;
                  nxt.bank_hi_valid = 1'b1;
               end
               CC_BANK_LSB: begin
                  emit              = 1'b0;
                  nxt.bank_lo       = q.data_two;
                  nxt.bank_lo_valid = 1'b1;
               end
               CC_NRPN_MSB, CC_RPN_MSB: begin
                  emit              = 1'b0;
                  nxt.is_rpn        = (q.data_one == CC_RPN_MSB);
                  nxt.num_msb       = q.data_two;
                  nxt.num_msb_valid = 1'b1;
               end
               CC_NRPN_LSB: begin
                  emit              = 1'b0;
                  nxt.is_rpn        = 1'b0;
                  nxt.num_lsb       = q.data_two;
                  nxt.num_lsb_valid = 1'b1;
               end
               CC_RPN_LSB: begin
                  emit = 1'b0;
                  // null parameter number clears the selection
                  if (cur.is_rpn && cur.num_msb_valid && cur.num_msb == NULL_NUMBER &&
                      q.data_two == NULL_NUMBER) begin
                     nxt = '{bank_hi_valid: cur.bank_hi_valid,
                             bank_lo_valid: cur.bank_lo_valid,
                             bank_hi: cur.bank_hi, bank_lo: cur.bank_lo,
                             default: '0};
                  end else begin
                     nxt.is_rpn        = 1'b1;
                     nxt.num_lsb       = q.data_two;
                     nxt.num_lsb_valid = 1'b1;
                  end
               end
               CC_DATA_MSB: begin
                  emit              = 1'b0;
                  nxt.val_msb       = q.data_two;
                  nxt.val_msb_valid = 1'b1;
               end
               CC_DATA_LSB: begin
                  emit = s1_range_ff && cur.num_msb_valid && cur.num_lsb_valid &&
                         cur.val_msb_valid;
                  rsp_in.out_kind    = cur.is_rpn ? OKIND_RPN : OKIND_NRPN;
                  rsp_in.key         = cur.num_msb;
                  rsp_in.param_index = cur.num_lsb;
                  rsp_in.wide_value  = widen_14_32({cur.val_msb, q.data_two});
               end
               CC_RESET_ALL: begin
                  nxt = '{bank_hi_valid: cur.bank_hi_valid,
                          bank_lo_valid: cur.bank_lo_valid,
                          bank_hi: cur.bank_hi, bank_lo: cur.bank_lo,
                          default: '0};
               end
               default: begin
               end
            endcase
         end
         KIND_PROGRAM: begin
            rsp_in.key = q.data_one;
            if (s1_range_ff && cur.bank_hi_valid && cur.bank_lo_valid) begin
               rsp_in.has_bank  = 1'b1;
               rsp_in.bank_high = cur.bank_hi;
               rsp_in.bank_low  = cur.bank_lo;
            end
         end
         KIND_CHAN_PRESS: begin
            rsp_in.wide_value = widen_7_32(q.data_one);
         end
         KIND_PITCH_BEND: begin
            rsp_in.wide_value = widen_14_32({q.data_two, q.data_one});
         end
         KIND_UNUSED: begin
            emit = 1'b0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.out_group   = rsp_ff.out_group;
   assign rsp_port.out_kind    = rsp_ff.out_kind;
   assign rsp_port.out_chan    = rsp_ff.out_chan;
   assign rsp_port.key         = rsp_ff.key;
   assign rsp_port.param_index = rsp_ff.param_index;
   assign rsp_port.has_bank    = rsp_ff.has_bank;
   assign rsp_port.bank_high   = rsp_ff.bank_high;
   assign rsp_port.bank_low    = rsp_ff.bank_low;
   assign rsp_port.wide_value  = rsp_ff.wide_value;

`ifndef SYNTHESIS
   a_valid_clear: assert property (@(posedge clock)
      reset |=> ent_valid_ff == '0)
      else $error("state valid flags not cleared by reset");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in the input stage");

   a_bypass: assert property (@(posedge clock) disable iff (reset)
      (acc && wr_en && s1_idx_ff == rd_idx) |=> rd_ff == $past(nxt))
      else $error("state bypass missed a same-entry write");

   a_bank_program: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.has_bank) |-> rsp_ff.out_kind == {1'b0, KIND_PROGRAM})
      else $error("bank attached to a non-program result");

   a_param_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.param_index != 7'd0) |->
         (rsp_ff.out_kind == OKIND_RPN || rsp_ff.out_kind == OKIND_NRPN))
      else $error("parameter index on a non-parameter result");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_midi1_to_midi2_channel_voice_translator.sv
`timescale 1ns / 1ps

module tb_midi1_to_midi2_channel_voice_translator;
   import m1m2_pkg::*;

   localparam int TOTAL_MSGS     = 500;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 40;
   localparam int SETTLE_CYCLES  = 8;

   typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_type;

   typedef struct packed {
      logic       bank_hi_ok;
      logic       bank_lo_ok;
      logic [6:0] bank_hi;
      logic [6:0] bank_lo;
      logic       is_rpn;
      logic       num_msb_ok;
      logic       num_lsb_ok;
      logic       data_msb_ok;
      logic [6:0] num_msb;
      logic [6:0] num_lsb;
      logic [6:0] data_msb;
   } voice_slot_type;

   logic clock = 1'b0;
   logic reset;

   m1m2_req_if req_if ();
   m1m2_rsp_if rsp_if ();

   midi1_to_midi2_channel_voice_translator dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   voice_slot_type voice_state [256];
   rsp_type     awaited_midi2_msgs [$];
   int          mismatches = 0;
   int          msgs_sent  = 0;
   int          burst_left = 0;
   bit          no_gaps    = 1'b0;
   bit          hold_request = 1'b0;
   logic [3:0]  slot_pool_group [4];
   logic [3:0]  slot_pool_chan [4];
   logic [6:0]  special_ccs [9];

   // min-center-max upscaling from src_bits to dst_bits
   function automatic logic [31:0] stretch_value(input logic [13:0] v, input int src_bits,
                                                 input int dst_bits);
      logic [63:0] r;
      logic [63:0] rep;
      int          up;
      int          low_bits;
      up       = dst_bits - src_bits;
      low_bits = src_bits - 1;
      r        = 64'(v) << up;
      if (64'(v) <= (64'd1 << low_bits)) return r[31:0];
      rep = 64'(v) & ((64'd1 << low_bits) - 64'd1);
      if (up > low_bits) rep = rep << (up - low_bits);
      else rep = rep >> (low_bits - up);
      while (rep != 64'd0) begin
         r   = r | rep;
         rep = rep >> low_bits;
      end
      return r[31:0];
   endfunction

   function automatic bit translate_to_midi2(input req_type m, output rsp_type r);
      logic [7:0]  slot;
      voice_slot_type s;
      bit          emit;
      slot        = {m.group, m.chan};
      s           = voice_state[slot];
      emit        = 1'b1;
      r           = '0;
      r.out_group = m.group;
      r.out_kind  = {1'b0, m.kind};
      r.out_chan  = m.chan;
      case (m.kind)
         KIND_NOTE_OFF, KIND_NOTE_ON: begin
            r.key        = m.data_one;
            r.wide_value = stretch_value(14'(m.data_two), 7, 16);
         end
         KIND_POLY_PRESS: begin
            r.key        = m.data_one;
            r.wide_value = stretch_value(14'(m.data_two), 7, 32);
         end
         KIND_CTRL: begin
            r.key        = m.data_one;
            r.wide_value = stretch_value(14'(m.data_two), 7, 32);
            case (m.data_one)
               CC_BANK_MSB: begin
                  s.bank_hi    = m.data_two;
                  s.bank_hi_ok = 1'b1;
                  emit         = 1'b0;
               end
               CC_BANK_LSB: begin
                  s.bank_lo    = m.data_two;
                  s.bank_lo_ok = 1'b1;
                  emit         = 1'b0;
               end
               CC_NRPN_MSB, CC_RPN_MSB: begin
                  s.is_rpn     = (m.data_one == CC_RPN_MSB);
                  s.num_msb    = m.data_two;
                  s.num_msb_ok = 1'b1;
                  emit         = 1'b0;
               end
               CC_NRPN_LSB: begin
                  s.is_rpn     = 1'b0;
                  s.num_lsb    = m.data_two;
                  s.num_lsb_ok = 1'b1;
                  emit         = 1'b0;
               end
               CC_RPN_LSB: begin
                  // null parameter number drops the whole selection
                  if (s.is_rpn && s.num_msb_ok && s.num_msb == NULL_NUMBER
                      && m.data_two == NULL_NUMBER) begin
                     s.is_rpn      = 1'b0;
                     s.num_msb_ok  = 1'b0;
                     s.num_lsb_ok  = 1'b0;
                     s.data_msb_ok = 1'b0;
                     s.num_msb     = '0;
                     s.num_lsb     = '0;
                     s.data_msb    = '0;
                  end else begin
                     s.is_rpn     = 1'b1;
                     s.num_lsb    = m.data_two;
                     s.num_lsb_ok = 1'b1;
                  end
                  emit = 1'b0;
               end
               CC_DATA_MSB: begin
                  s.data_msb    = m.data_two;
                  s.data_msb_ok = 1'b1;
                  emit          = 1'b0;
               end
               CC_DATA_LSB: begin
                  if (s.num_msb_ok && s.num_lsb_ok && s.data_msb_ok) begin
                     r.out_kind    = s.is_rpn ? OKIND_RPN : OKIND_NRPN;
                     r.key         = s.num_msb;
                     r.param_index = s.num_lsb;
                     r.wide_value  = stretch_value({s.data_msb, m.data_two}, 14, 32);
                  end else begin
                     emit = 1'b0;
                  end
               end
               CC_RESET_ALL: begin
                  s.is_rpn      = 1'b0;
                  s.num_msb_ok  = 1'b0;
                  s.num_lsb_ok  = 1'b0;
                  s.data_msb_ok = 1'b0;
                  s.num_msb     = '0;
                  s.num_lsb     = '0;
                  s.data_msb    = '0;
               end
               default: begin
               end
            endcase
         end
         KIND_PROGRAM: begin
            r.key = m.data_one;
            if (s.bank_hi_ok && s.bank_lo_ok) begin
               r.has_bank  = 1'b1;
               r.bank_high = s.bank_hi;
               r.bank_low  = s.bank_lo;
            end
         end
         KIND_CHAN_PRESS: begin
            r.wide_value = stretch_value(14'(m.data_one), 7, 32);
         end
         KIND_PITCH_BEND: begin
            r.wide_value = stretch_value({m.data_two, m.data_one}, 14, 32);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
      voice_state[slot] = s;
      return emit;
   endfunction

   task automatic send_msg(input logic [3:0] grp, input logic [2:0] kind,
                           input logic [3:0] chn, input logic [6:0] d1, input logic [6:0] d2);
      req_type m;
      rsp_type r;
      int      gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = no_gaps ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid    <= 1'b1;
      req_if.group    <= grp;
      req_if.kind     <= kind;
      req_if.chan     <= chn;
      req_if.data_one <= d1;
      req_if.data_two <= d2;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      m.group    = grp;
      m.kind     = kind;
      m.chan     = chn;
      m.data_one = d1;
      m.data_two = d2;
      if (translate_to_midi2(m, r)) awaited_midi2_msgs.push_back(r);
      if (kind != KIND_UNUSED) msgs_sent++;
   endtask

   task automatic send_cc(input logic [3:0] grp, input logic [3:0] chn,
                          input logic [6:0] ctrl, input logic [6:0] value);
      send_msg(grp, KIND_CTRL, chn, ctrl, value);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (awaited_midi2_msgs.size() != 0) @(posedge clock);
   endtask

   function automatic logic [6:0] rand7();
      logic [6:0] edges [4];
      edges = '{7'd0, 7'd64, 7'd65, 7'd127};
      if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 3)];
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic pick_slot(output logic [3:0] grp, output logic [3:0] chn);
      int n;
      if ($urandom_range(0, 1) == 0) begin
         grp = 4'($urandom_range(0, 15));
         chn = 4'($urandom_range(0, 15));
      end else begin
         n   = $urandom_range(0, 3);
         grp = slot_pool_group[n];
         chn = slot_pool_chan[n];
      end
   endtask

   task automatic test_note_and_pressure();
      send_msg(4'd0, KIND_NOTE_OFF, 4'd0, 7'd0, 7'd0);
      send_msg(4'd15, KIND_NOTE_ON, 4'd15, 7'd127, 7'd127);
      send_msg(4'd3, KIND_NOTE_ON, 4'd9, 7'd60, 7'd65);
      send_msg(4'd7, KIND_POLY_PRESS, 4'd2, 7'd127, 7'd64);
      send_msg(4'd7, KIND_CHAN_PRESS, 4'd2, 7'd127, 7'd85);
      send_msg(4'd1, KIND_PITCH_BEND, 4'd4, 7'd0, 7'd0);
      send_msg(4'd1, KIND_PITCH_BEND, 4'd4, 7'd0, 7'd64);
      send_msg(4'd1, KIND_PITCH_BEND, 4'd4, 7'd127, 7'd127);
      send_msg(4'd2, KIND_UNUSED, 4'd5, 7'd127, 7'd127);
   endtask

   task automatic test_bank_program();
      send_msg(4'd5, KIND_PROGRAM, 4'd6, 7'd10, 7'd99);
      send_cc(4'd5, 4'd6, CC_BANK_MSB, 7'd5);
      send_cc(4'd5, 4'd6, CC_BANK_LSB, 7'd127);
      send_msg(4'd5, KIND_PROGRAM, 4'd6, 7'd127, 7'd0);
   endtask

   task automatic test_parameter_numbers();
      send_cc(4'd9, 4'd1, CC_RPN_MSB, 7'd0);
      send_cc(4'd9, 4'd1, CC_RPN_LSB, 7'd0);
      send_cc(4'd9, 4'd1, CC_DATA_MSB, 7'd127);
      send_cc(4'd9, 4'd1, CC_DATA_LSB, 7'd127);
      // switches the selection to non-registered, keeps the lsb
      send_cc(4'd9, 4'd1, CC_NRPN_MSB, 7'd127);
      send_cc(4'd9, 4'd1, CC_DATA_LSB, 7'd0);
      // null rpn
      send_cc(4'd9, 4'd1, CC_RPN_MSB, NULL_NUMBER);
      send_cc(4'd9, 4'd1, CC_RPN_LSB, NULL_NUMBER);
      send_cc(4'd9, 4'd1, CC_DATA_LSB, 7'd5);
      // reset all controllers passes through and drops the number
      send_cc(4'd9, 4'd1, CC_RPN_MSB, 7'd1);
      send_cc(4'd9, 4'd1, CC_RPN_LSB, 7'd2);
      send_cc(4'd9, 4'd1, CC_DATA_MSB, 7'd127);
      send_cc(4'd9, 4'd1, CC_RESET_ALL, 7'd127);
      send_cc(4'd9, 4'd1, CC_DATA_LSB, 7'd3);
   endtask

   task automatic test_backpressure();
      no_gaps      = 1'b1;
      hold_request = 1'b1;
      repeat (16) send_msg(4'($urandom_range(0, 15)), KIND_NOTE_ON,
                           4'($urandom_range(0, 15)), rand7(), rand7());
      no_gaps = 1'b0;
   endtask

   task automatic test_random_traffic();
      logic [3:0] g;
      logic [3:0] c;
      int         pick;
      bit         rpn;
      for (int i = 0; i < 4; i++) begin
         slot_pool_group[i] = 4'($urandom_range(0, 15));
         slot_pool_chan[i]  = 4'($urandom_range(0, 15));
      end
      while (msgs_sent < TOTAL_MSGS) begin
         pick_slot(g, c);
         pick = $urandom_range(0, 9);
         if (pick <= 2) begin
            send_msg(g, 3'($urandom_range(0, 6)), c, rand7(), rand7());
         end else if (pick == 3) begin
            if ($urandom_range(0, 3) != 0) send_cc(g, c, CC_BANK_MSB, rand7());
            if ($urandom_range(0, 3) != 0) send_cc(g, c, CC_BANK_LSB, rand7());
            send_msg(g, KIND_PROGRAM, c, rand7(), rand7());
         end else if (pick <= 6) begin
            rpn = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 7) != 0)
               send_cc(g, c, rpn ? CC_RPN_MSB : CC_NRPN_MSB, rand7());
            if ($urandom_range(0, 7) != 0)
               send_cc(g, c, rpn ? CC_RPN_LSB : CC_NRPN_LSB, rand7());
            if ($urandom_range(0, 7) != 0) send_cc(g, c, CC_DATA_MSB, rand7());
            repeat ($urandom_range(1, 3)) send_cc(g, c, CC_DATA_LSB, rand7());
         end else if (pick == 7) begin
            send_cc(g, c, CC_RPN_MSB, NULL_NUMBER);
            send_cc(g, c, CC_RPN_LSB, $urandom_range(0, 1) ? NULL_NUMBER : rand7());
            send_cc(g, c, CC_DATA_LSB, rand7());
         end else if (pick == 8) begin
            send_cc(g, c, CC_RESET_ALL, rand7());
            send_cc(g, c, CC_DATA_LSB, rand7());
         end else begin
            send_msg(g, 3'($urandom_range(0, 7)), c,
                     $urandom_range(0, 1) ? special_ccs[$urandom_range(0, 8)] : rand7(),
                     rand7());
         end
      end
   endtask

   // receiver stall pattern
   rx_mode_type rx_mode  = RX_STEADY;
   int       rx_left     = 0;
   int       hold_left   = 0;
   int       rx_cycle    = 0;

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      rx_cycle++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_STEADY:   rsp_if.ready <= 1'b1;
            RX_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_if.ready <= (rx_cycle % 3 != 0);
         endcase
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (awaited_midi2_msgs.size() == 0) begin
            $display("%0t: unexpected item, expected none, got kind %h key %h value %h",
                     $time, rsp_if.out_kind, rsp_if.key, rsp_if.wide_value);
            mismatches++;
         end else begin
            want = awaited_midi2_msgs.pop_front();
            check_field("out_group", 32'(want.out_group), 32'(rsp_if.out_group));
            check_field("out_kind", 32'(want.out_kind), 32'(rsp_if.out_kind));
            check_field("out_chan", 32'(want.out_chan), 32'(rsp_if.out_chan));
            check_field("key", 32'(want.key), 32'(rsp_if.key));
            check_field("param_index", 32'(want.param_index), 32'(rsp_if.param_index));
            check_field("has_bank", 32'(want.has_bank), 32'(rsp_if.has_bank));
            check_field("bank_high", 32'(want.bank_high), 32'(rsp_if.bank_high));
            check_field("bank_low", 32'(want.bank_low), 32'(rsp_if.bank_low));
            check_field("wide_value", want.wide_value, rsp_if.wide_value);
         end
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** midi1_to_midi2_channel_voice_translator: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.group    = '0;
      req_if.kind     = KIND_NOTE_OFF;
      req_if.chan     = '0;
      req_if.data_one = '0;
      req_if.data_two = '0;
      rsp_if.ready    = 1'b0;
      foreach (voice_state[i]) voice_state[i] = '0;
      special_ccs = '{CC_BANK_MSB, CC_BANK_LSB, CC_NRPN_MSB, CC_NRPN_LSB, CC_RPN_MSB,
                      CC_RPN_LSB, CC_DATA_MSB, CC_DATA_LSB, CC_RESET_ALL};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_note_and_pressure();
      test_bank_program();
      test_parameter_numbers();
      wait_idle();
      test_backpressure();
      wait_idle();
      test_random_traffic();
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && awaited_midi2_msgs.size() == 0) begin
         $display("** midi1_to_midi2_channel_voice_translator: PASSED **");
      end else begin
         $display("** midi1_to_midi2_channel_voice_translator: FAILED **");
      end
      $finish;
   end

endmodule
